// ----- rtl/core/msm_pkg.sv -----
// types, constants and command codes shared by the moment statistics merge block
package msm_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 40;
    localparam int SQ_BITS     = 56;
    localparam int MEAN_BITS   = 16;
    localparam int VAR_BITS    = 32;
    localparam int ROOT_BITS   = 16;
    localparam int SQR_BITS    = 2 * SAMPLE_BITS;
    localparam int MSQ_BITS    = 2 * MEAN_BITS;

    localparam int DIV_STEPS   = SQ_BITS;
    localparam int SQRT_STEPS  = ROOT_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

    localparam logic [SQ_BITS-1:0] MEAN_POS_LIM = SQ_BITS'(2 ** (MEAN_BITS - 1) - 1);
    localparam logic [SQ_BITS-1:0] MEAN_NEG_LIM = SQ_BITS'(2 ** (MEAN_BITS - 1));

    typedef enum logic [1:0] {
        CMD_START        = 2'd0,
        CMD_MERGE_SAMPLE = 2'd1,
        CMD_MERGE_PART   = 2'd2,
        CMD_LOAD         = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [COUNT_BITS-1:0]         part_count;
        logic signed [SUM_BITS-1:0]    part_sum;
        logic [SQ_BITS-1:0]            part_sum_sq;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        count;
        logic signed [MEAN_BITS-1:0]  mean;
        logic [VAR_BITS-1:0]          variance;
        logic [ROOT_BITS-1:0]         deviation;
        logic                         overflow;
        logic                         empty_res;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_DIV_INIT,
        ST_DIV,
        ST_MEAN,
        ST_VAR,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic square;
        logic update;
        logic div_start;
        logic mean_en;
        logic var_en;
        logic sqrt_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/msm_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module msm_div import msm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SQ_BITS-1:0]    i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic [SQ_BITS-1:0]    o_quotient,
    output logic                  o_busy
);

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS-1:0] r_rem;
    logic [SQ_BITS-1:0]    r_quo;

    logic [COUNT_BITS+1:0] w_diff;
    logic                  w_ge;

    assign w_diff = {1'b0, r_rem, r_quo[SQ_BITS-1]} - {2'b00, r_div};
    assign w_ge   = !w_diff[COUNT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : {r_rem[COUNT_BITS-2:0], r_quo[SQ_BITS-1]};
            r_quo <= {r_quo[SQ_BITS-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

// ----- rtl/core/msm_sqrt.sv -----
// floor square root, one result bit per cycle
module msm_sqrt import msm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VAR_BITS-1:0]  i_radicand,
    output logic [ROOT_BITS-1:0] o_root,
    output logic                 o_busy
);

    localparam int REM_BITS = ROOT_BITS + 2;

    logic                  r_busy;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic [VAR_BITS-1:0]   r_rad;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;

    logic [REM_BITS+1:0]   w_rem_sh;
    logic [REM_BITS+2:0]   w_diff;
    logic                  w_ge;

    assign w_rem_sh = {r_rem, r_rad[VAR_BITS-1 -: 2]};
    assign w_diff   = {1'b0, w_rem_sh} - {3'b000, r_root, 2'b01};
    assign w_ge     = !w_diff[REM_BITS+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQRT_CNT_W'(SQRT_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[VAR_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_BITS-1:0] : w_rem_sh[REM_BITS-1:0];
            r_root <= {r_root[ROOT_BITS-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;

endmodule

// ----- rtl/core/msm_dpath.sv -----
// accumulator registers, update arithmetic, dividers, square root and result register
module msm_dpath import msm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_req    i_in_req,
    input  logic       i_out_ready,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_req   o_out_res
);

    t_in_req                     r_in;
    logic [SQR_BITS-1:0]         r_sq;
    logic [COUNT_BITS-1:0]       r_count;
    logic [SUM_BITS-1:0]         r_sum;
    logic [SQ_BITS-1:0]          r_sum_sq;
    logic                        r_ovf;
    logic signed [MEAN_BITS-1:0] r_mean;
    logic [MSQ_BITS-1:0]         r_msq;
    logic [VAR_BITS-1:0]         r_var;
    logic                        r_out_valid;
    t_out_req                    r_out_res;

    logic signed [SQR_BITS-1:0]  w_sq_full;
    logic [SUM_BITS:0]           w_s_ext;
    logic [SQ_BITS:0]            w_sq_ext;
    logic [COUNT_BITS:0]         w_nc;
    logic [SUM_BITS:0]           w_ns;
    logic [SQ_BITS:0]            w_nss;
    logic                        w_ovf;

    logic                        w_neg;
    logic [SUM_BITS-1:0]         w_sum_mag;
    logic [SQ_BITS-1:0]          w_q_sum;
    logic [SQ_BITS-1:0]          w_q_sq;
    logic                        w_busy_sum;
    logic                        w_busy_sq;
    logic signed [MEAN_BITS-1:0] w_mean;
    logic signed [MSQ_BITS-1:0]  w_msq_full;
    logic [SQ_BITS-1:0]          w_msq_ext;
    logic [SQ_BITS-1:0]          w_vdiff;
    logic [VAR_BITS-1:0]         w_var;
    logic [ROOT_BITS-1:0]        w_root;
    logic                        w_sqrt_busy;
    logic                        w_empty;

    // sample square and update sums
    assign w_sq_full = r_in.sample * r_in.sample;
    assign w_s_ext   = {{(SUM_BITS + 1 - SAMPLE_BITS){r_in.sample[SAMPLE_BITS-1]}}, r_in.sample};
    assign w_sq_ext  = {(SQ_BITS + 1 - SQR_BITS)'(0), r_sq};

    always_comb begin
        case (r_in.cmd)
            CMD_START: begin
                w_nc  = (COUNT_BITS + 1)'(1);
                w_ns  = w_s_ext;
                w_nss = w_sq_ext;
            end
            CMD_MERGE_SAMPLE: begin
                w_nc  = {1'b0, r_count} + (COUNT_BITS + 1)'(1);
                w_ns  = {r_sum[SUM_BITS-1], r_sum} + w_s_ext;
                w_nss = {1'b0, r_sum_sq} + w_sq_ext;
            end
            CMD_MERGE_PART: begin
                w_nc  = {1'b0, r_count} + {1'b0, r_in.part_count};
                w_ns  = {r_sum[SUM_BITS-1], r_sum}
                      + {r_in.part_sum[SUM_BITS-1], r_in.part_sum};
                w_nss = {1'b0, r_sum_sq} + {1'b0, r_in.part_sum_sq};
            end
            default: begin
                w_nc  = {1'b0, r_in.part_count};
                w_ns  = {r_in.part_sum[SUM_BITS-1], r_in.part_sum};
                w_nss = {1'b0, r_in.part_sum_sq};
            end
        endcase
    end

    assign w_ovf = w_nc[COUNT_BITS] | (w_ns[SUM_BITS] != w_ns[SUM_BITS-1]) | w_nss[SQ_BITS];

    // dividers for mean and mean square
    assign w_neg     = r_sum[SUM_BITS-1];
    assign w_sum_mag = w_neg ? (~r_sum + 1'b1) : r_sum;

    msm_div u_div_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({(SQ_BITS - SUM_BITS)'(0), w_sum_mag}),
        .i_divisor  (r_count),
        .o_quotient (w_q_sum),
        .o_busy     (w_busy_sum)
    );

    msm_div u_div_sq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum_sq),
        .i_divisor  (r_count),
        .o_quotient (w_q_sq),
        .o_busy     (w_busy_sq)
    );

    // saturated mean and its square
    always_comb begin
        if (w_neg) begin
            if (w_q_sum > MEAN_NEG_LIM) begin
                w_mean = MEAN_NEG_LIM[MEAN_BITS-1:0];
            end else begin
                w_mean = ~w_q_sum[MEAN_BITS-1:0] + 1'b1;
            end
        end else begin
            if (w_q_sum > MEAN_POS_LIM) begin
                w_mean = MEAN_POS_LIM[MEAN_BITS-1:0];
            end else begin
                w_mean = w_q_sum[MEAN_BITS-1:0];
            end
        end
    end

    assign w_msq_full = w_mean * w_mean;

    // variance clamped at zero and saturated
    assign w_msq_ext = {(SQ_BITS - MSQ_BITS)'(0), r_msq};
    assign w_vdiff   = w_q_sq - w_msq_ext;

    always_comb begin
        if (w_q_sq <= w_msq_ext) begin
            w_var = '0;
        end else if (|w_vdiff[SQ_BITS-1:VAR_BITS]) begin
            w_var = '1;
        end else begin
            w_var = w_vdiff[VAR_BITS-1:0];
        end
    end

    msm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (r_var),
        .o_root     (w_root),
        .o_busy     (w_sqrt_busy)
    );

    assign w_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sum_sq    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update && !w_ovf) begin
                r_count  <= w_nc[COUNT_BITS-1:0];
                r_sum    <= w_ns[SUM_BITS-1:0];
                r_sum_sq <= w_nss[SQ_BITS-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_req;
        end
        if (i_cmd.square) begin
            r_sq <= unsigned'(w_sq_full);
        end
        if (i_cmd.update) begin
            r_ovf <= w_ovf;
        end
        if (i_cmd.mean_en) begin
            r_mean <= w_mean;
            r_msq  <= unsigned'(w_msq_full);
        end
        if (i_cmd.var_en) begin
            r_var <= w_var;
        end
        if (i_cmd.out_load) begin
            r_out_res.count     <= r_count;
            r_out_res.mean      <= w_empty ? '0 : r_mean;
            r_out_res.variance  <= w_empty ? '0 : r_var;
            r_out_res.deviation <= w_empty ? '0 : w_root;
            r_out_res.overflow  <= r_ovf;
            r_out_res.empty_res <= w_empty;
        end
    end

    assign o_status.div_busy  = w_busy_sum | w_busy_sq;
    assign o_status.sqrt_busy = w_sqrt_busy;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_res          = r_out_res;

endmodule

// ----- rtl/core/msm_ctrl.sv -----
// sequencer that steps one request through update, division and square root
module msm_ctrl import msm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                o_cmd.mean_en = 1'b1;
                n_state       = ST_VAR;
            end
            ST_VAR: begin
                o_cmd.var_en = 1'b1;
                n_state      = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_SQRT;
            end
            ST_SQRT: begin
                if (!i_status.sqrt_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/moment_stat_merge.sv -----
// moment statistics merge: top level joining sequencer and datapath
// the time from request accept to result valid is set by the two parallel
// 56-step dividers (one quotient bit per cycle), the 16-step square root and sequencing
// one request in flight; a new request is accepted only after the previous result is loaded,
// a stalled output holds the sequencer until the output register frees
// synchronous active-low reset clears count, sum and sum of squares to zero
module moment_stat_merge import msm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_res
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    msm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    msm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a previous one is still in flight");

    a_units_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_status.div_busy && !w_status.sqrt_busy))
        else $error("arithmetic unit busy while accepting requests");

    a_empty_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.empty_res) |->
            (o_out_res.mean == '0 && o_out_res.variance == '0 && o_out_res.deviation == '0))
        else $error("empty result carries nonzero statistics");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({16'b0, o_out_res.deviation} * {16'b0, o_out_res.deviation})
            <= o_out_res.variance))
        else $error("deviation squared exceeds variance");

endmodule
